>>> hw/rtl/ger_pkg.sv
// ----------------------------------------------------------------------------
// ger_pkg: shared types and constants of the gamepad event remapper
// Item layouts of both channels, the stored binding and the field codes.
// ----------------------------------------------------------------------------
package ger_pkg;

   localparam int CODE_W      = 10;
   localparam int MAX_RESULTS = 4;

   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [1:0] KIND_BUTTON = 2'd0;
   localparam logic [1:0] KIND_AXIS   = 2'd1;
   localparam logic [1:0] KIND_HAT    = 2'd2;
   localparam logic [1:0] KIND_SPARE  = 2'd3;

   localparam logic DEST_AXIS   = 1'b0;
   localparam logic DEST_BUTTON = 1'b1;

   localparam logic [1:0] RANGE_FULL  = 2'd0;
   localparam logic [1:0] RANGE_NEG   = 2'd1;
   localparam logic [1:0] RANGE_POS   = 2'd2;
   localparam logic [1:0] RANGE_SPARE = 2'd3;

   // Q1.15 full scale and one half.
   localparam logic signed [15:0] Q_ONE     = 16'sd32767;
   localparam logic signed [15:0] Q_MIN     = -16'sd32768;
   localparam logic [16:0]        Q_HALF    = 17'd16384;

   typedef struct packed {
      logic                opcode;
      logic [1:0]          source_kind;
      logic [5:0]          source_index;
      logic signed [15:0]  event_value;
      logic [1:0]          slot;
      logic                bind_valid;
      logic                bind_dest_kind;
      logic [CODE_W-1:0]   bind_dest_code;
      logic [1:0]          bind_dest_range;
      logic [1:0]          bind_src_range;
      logic                bind_invert;
   } req_type;

   typedef struct packed {
      logic                out_kind;
      logic [CODE_W-1:0]   out_code;
      logic signed [15:0]  axis_value;
      logic                pressed;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic                dest_kind;
      logic [CODE_W-1:0]   code;
      logic [1:0]          dest_range;
      logic [1:0]          src_range;
      logic                invert;
   } bind_type;

endpackage

>>> hw/rtl/ger_chan_if.sv
// ----------------------------------------------------------------------------
// ger_chan_if: valid/ready channel
// Carries one payload item per handshake from a source to a sink.
// ----------------------------------------------------------------------------
interface ger_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/gamepad_event_remapper.sv
// ----------------------------------------------------------------------------
// gamepad_event_remapper: binding table lookup for raw gamepad events
//
//   channel    dir   payload    handshake
//   req_chan   in    req_type   valid/ready, accepted when both high
//   rsp_chan   out   rsp_type   valid/ready, accepted when both high
//
// An event is accepted, walks its slots (up to four) one after another and is
// then closed; the binding memory has a single read port. After reset the
// memory is swept to invalid, one entry a cycle, through all 3 * 2^(IXW + SLW)
// entries (768 at the default sizes); no item is accepted during the sweep.
// A stalled result channel holds the walk; the output register lets a new
// item in while the last result of the previous one waits.
// ----------------------------------------------------------------------------
module gamepad_event_remapper
   import ger_pkg::*;
#(
   parameter int SOURCE_INDICES   = 64,
   parameter int SLOTS_PER_SOURCE = 4,
   parameter int CODE_BITS        = 10
) (
   input  logic        clock,
   input  logic        reset,
   ger_chan_if.sink    req_chan,
   ger_chan_if.source  rsp_chan
);

   localparam int IXW   = (SOURCE_INDICES > 1) ? $clog2(SOURCE_INDICES) : 1;
   localparam int SLW   = (SLOTS_PER_SOURCE > 1) ? $clog2(SLOTS_PER_SOURCE) : 1;
   localparam int AW    = 2 + IXW + SLW;
   localparam int DEPTH = 3 * (1 << (IXW + SLW));
   localparam int WALK  = (SLOTS_PER_SOURCE < MAX_RESULTS) ? SLOTS_PER_SOURCE
                                                          : MAX_RESULTS;
   localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [1:0]        LAST_SLOT = 2'(WALK - 1);
   localparam logic [CODE_W-1:0] CODE_MASK = (CODE_BITS >= CODE_W) ? {CODE_W{1'b1}}
                                             : CODE_W'((1 << CODE_BITS) - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   // Control state.
   logic [1:0]          state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [1:0]          walk_ff, walk_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [1:0]          kind_ff, kind_in;
   logic [IXW-1:0]      index_ff, index_in;
   logic signed [15:0]  value_ff, value_in;
   rsp_type             pend_ff, pend_in;
   rsp_type             out_ff, out_in;

   // Binding memory.
   bind_type            mem [DEPTH];
   bind_type            rd_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_wa;
   bind_type            mem_wd;
   logic [AW-1:0]       mem_ra;

   logic                req_acc;
   logic                kind_ok;
   logic                index_ok;
   logic                slot_ok;
   logic                out_free;
   logic                need_push;
   logic                advance;
   logic [1:0]          next_slot;

   // Mapping of the current slot.
   logic signed [15:0]  clip_v;
   logic signed [15:0]  inv_v;
   logic signed [17:0]  dn;
   logic signed [17:0]  up;
   logic [16:0]         mag;
   logic                hat_pos;
   logic                hat_neg;
   logic                hat_bad;
   logic                map_ok;
   logic                emit;
   rsp_type             map_res;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign kind_ok  = req_chan.data.source_kind != KIND_SPARE;
   assign index_ok = int'(req_chan.data.source_index) < SOURCE_INDICES;
   assign slot_ok  = int'(req_chan.data.slot) < SLOTS_PER_SOURCE;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = out_ff;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign emit      = rd_ff.valid && map_ok;
   assign need_push = emit && pend_valid_ff;
   assign advance   = !need_push || out_free;
   assign next_slot = walk_ff + 2'd1;

   // Memory port control.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = {req_chan.data.source_kind, IXW'(req_chan.data.source_index),
                SLW'(req_chan.data.slot)};
      mem_wd = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
      end else if (req_acc && req_chan.data.opcode == OP_WRITE && kind_ok && index_ok
                   && slot_ok) begin
         mem_we            = 1'b1;
         mem_wd.valid      = req_chan.data.bind_valid;
         mem_wd.dest_kind  = req_chan.data.bind_dest_kind;
         mem_wd.code       = req_chan.data.bind_dest_code & CODE_MASK;
         mem_wd.dest_range = req_chan.data.bind_dest_range;
         mem_wd.src_range  = req_chan.data.bind_src_range;
         mem_wd.invert     = req_chan.data.bind_invert;
      end
      if (state_ff == ST_WALK) begin
         mem_ra = {kind_ff, index_ff, SLW'(advance ? next_slot : walk_ff)};
      end else begin
         mem_ra = {req_chan.data.source_kind, IXW'(req_chan.data.source_index),
                   SLW'(2'd0)};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   // Maps the binding read for the current slot.
   always_comb begin
      clip_v = value_ff;
      if (rd_ff.src_range == RANGE_NEG && value_ff > 16'sd0) begin
         clip_v = '0;
      end
      if (rd_ff.src_range == RANGE_POS && value_ff < 16'sd0) begin
         clip_v = '0;
      end
      if (!rd_ff.invert) begin
         inv_v = clip_v;
      end else if (clip_v == Q_MIN) begin
         inv_v = Q_ONE;
      end else begin
         inv_v = -clip_v;
      end
      dn = 18'(inv_v) - 18'sd32767;
      if (dn < 18'sd0) begin
         dn = dn + 18'sd1;
      end
      up      = 18'(inv_v) + 18'sd32767;
      mag     = clip_v[15] ? (17'd0 - {1'b1, clip_v}) : {1'b0, clip_v};
      hat_pos = !value_ff[15] && (value_ff != 16'sd0);
      hat_neg = value_ff[15];
      hat_bad = (rd_ff.src_range == RANGE_NEG && hat_pos)
                || (rd_ff.src_range == RANGE_POS && hat_neg);

      map_ok           = 1'b1;
      map_res          = '0;
      map_res.out_kind = rd_ff.dest_kind;
      map_res.out_code = rd_ff.code;

      unique case (kind_ff)
         KIND_BUTTON: begin
            if (rd_ff.dest_kind == DEST_AXIS) begin
               unique case (rd_ff.dest_range)
                  RANGE_NEG:             map_res.axis_value = (value_ff != 16'sd0) ? -Q_ONE : '0;
                  RANGE_FULL, RANGE_POS: map_res.axis_value = (value_ff != 16'sd0) ? Q_ONE : '0;
                  default:               map_res.axis_value = '0;
               endcase
            end else begin
               map_res.pressed = value_ff != 16'sd0;
            end
         end
         KIND_AXIS: begin
            if (rd_ff.dest_kind == DEST_AXIS) begin
               unique case (rd_ff.dest_range)
                  RANGE_FULL: map_res.axis_value = inv_v;
                  RANGE_NEG:  map_res.axis_value = 16'(dn >>> 1);
                  RANGE_POS:  map_res.axis_value = up[17] ? '0 : 16'(up >>> 1);
                  default:    map_res.axis_value = '0;
               endcase
            end else if (rd_ff.src_range == RANGE_FULL) begin
               map_res.pressed = rd_ff.invert ? (clip_v < 16'sd0) : (clip_v > 16'sd0);
            end else begin
               map_res.pressed = rd_ff.invert ? (mag < Q_HALF) : (mag > Q_HALF);
            end
         end
         default: begin
            // Hat: an axis binding on the opposite half stays silent.
            if (rd_ff.dest_kind == DEST_AXIS) begin
               map_ok             = !hat_bad;
               map_res.axis_value = (value_ff != 16'sd0) ? Q_ONE : '0;
            end else begin
               map_res.pressed = !hat_bad && (value_ff != 16'sd0);
            end
         end
      endcase
   end

   // Sequencer: the newest result waits in the pending register so that the
   // last flag can be set once the walk has seen every slot.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      walk_in       = walk_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      kind_in       = kind_ff;
      index_in      = index_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_in        = out_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc && req_chan.data.opcode == OP_EVENT && kind_ok && index_ok) begin
               state_in = ST_WALK;
               walk_in  = 2'd0;
               kind_in  = req_chan.data.source_kind;
               index_in = IXW'(req_chan.data.source_index);
               value_in = req_chan.data.event_value;
            end
         end
         ST_WALK: begin
            if (advance) begin
               if (need_push) begin
                  rsp_valid_in = 1'b1;
                  out_in       = pend_ff;
               end
               if (emit) begin
                  pend_valid_in = 1'b1;
                  pend_in       = map_res;
               end
               if (walk_ff == LAST_SLOT) begin
                  state_in = ST_FLUSH;
               end else begin
                  walk_in = next_slot;
               end
            end
         end
         default: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         walk_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         walk_ff       <= walk_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      index_ff <= index_in;
      value_ff <= value_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   // A pending result only lives while an event is being walked or closed.
   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_WALK || state_ff == ST_FLUSH))
      else $error("pending result outside of an event walk");

   // Closing an event with a pending result delivers it as the last one.
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && pend_valid_ff && out_free)
      |=> (rsp_valid_ff && out_ff.last && state_ff == ST_IDLE))
      else $error("close of an event did not deliver the last result");

   // The walk never goes beyond the slots of one source.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (walk_ff <= LAST_SLOT))
      else $error("slot walk out of range");

   // The table is written only by the sweep or by an accepted binding write.
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR
                  || (req_acc && req_chan.data.opcode == OP_WRITE)))
      else $error("binding memory written outside a sweep or a write item");

endmodule

>>> tb/tb_gamepad_event_remapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gamepad_event_remapper: self-checking bench for the event remapper
// Drives binding writes and raw button, axis and hat events through the
// request channel with bursty timing. It mirrors the binding table and checks
// every mapped result, field by field, against the predicted sequence while
// the result channel stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_gamepad_event_remapper;
   import ger_pkg::*;

   localparam int Q15_ONE       = 32767;
   localparam int Q15_HALF      = 16384;
   localparam int RANDOM_ITEMS  = 335;
   localparam int REPORT_LIMIT  = 10;

   logic clock = 1'b0;
   logic reset;

   ger_chan_if #(.payload_type(req_type)) req_chan ();
   ger_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   gamepad_event_remapper uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   bind_type binding_mirror [0:2][0:63][0:3];
   req_type  pending_q [$];
   rsp_type  mapped_q [$];

   int sent_count     = 0;
   int accept_count   = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   int stall_left     = 0;
   int stall_cycle    = 0;
   int mismatch_count = 0;
   int results_seen   = 0;
   int writes_seen    = 0;
   int events_seen    = 0;
   int ignored_seen   = 0;
   int hot_index [4]  = '{0, 63, 21, 42};
   rsp_type want_rsp;

   function automatic int clamp_q15(input int x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
   endfunction

   // Maps one source value through one binding; returns 0 when the binding
   // produces no event (an axis bound to the wrong half of a hat).
   function automatic logic map_binding(input bind_type b, input logic [1:0] kind,
                                        input int v, output rsp_type r);
      int   a;
      int   axis;
      logic hit;
      logic off_side;
      r = '0;
      r.out_kind = b.dest_kind;
      r.out_code = b.code;
      axis = 0;
      hit = 1'b0;
      if (kind == KIND_BUTTON) begin
         if (b.dest_kind == DEST_AXIS) begin
            if (b.dest_range == RANGE_NEG) axis = (v != 0) ? -Q15_ONE : 0;
            else if (b.dest_range != RANGE_SPARE) axis = (v != 0) ? Q15_ONE : 0;
         end else begin
            hit = (v != 0);
         end
      end else if (kind == KIND_AXIS) begin
         a = v;
         if (b.src_range == RANGE_NEG && a > 0) a = 0;
         if (b.src_range == RANGE_POS && a < 0) a = 0;
         if (b.dest_kind == DEST_AXIS) begin
            if (b.invert) a = clamp_q15(-a);
            case (b.dest_range)
               RANGE_FULL: axis = a;
               RANGE_NEG:  axis = clamp_q15((a - Q15_ONE) / 2);
               RANGE_POS:  axis = clamp_q15((a + Q15_ONE) / 2);
               default:    axis = 0;
            endcase
         end else if (b.src_range == RANGE_FULL) begin
            hit = b.invert ? (a < 0) : (a > 0);
         end else begin
            if (a < 0) a = -a;
            hit = b.invert ? (a < Q15_HALF) : (a > Q15_HALF);
         end
      end else begin
         off_side = (b.src_range == RANGE_NEG && v > 0) || (b.src_range == RANGE_POS && v < 0);
         if (b.dest_kind == DEST_AXIS) begin
            if (off_side) return 1'b0;
            axis = (v != 0) ? Q15_ONE : 0;
         end else begin
            hit = !off_side && (v != 0);
         end
      end
      r.axis_value = axis[15:0];
      r.pressed    = hit;
      return 1'b1;
   endfunction

   // Applies one accepted item to the mirrored table and queues its results.
   function automatic void remap_item(input req_type item);
      rsp_type  found [$];
      rsp_type  one;
      bind_type b;
      int       v;
      if (item.source_kind == KIND_SPARE) begin
         ignored_seen++;
         return;
      end
      if (item.opcode == OP_WRITE) begin
         b.valid      = item.bind_valid;
         b.dest_kind  = item.bind_dest_kind;
         b.code       = item.bind_dest_code;
         b.dest_range = item.bind_dest_range;
         b.src_range  = item.bind_src_range;
         b.invert     = item.bind_invert;
         binding_mirror[item.source_kind][item.source_index][item.slot] = b;
         writes_seen++;
         return;
      end
      events_seen++;
      v = $signed(item.event_value);
      for (int s = 0; s < 4; s++) begin
         b = binding_mirror[item.source_kind][item.source_index][s];
         if (b.valid && map_binding(b, item.source_kind, v, one)) found.push_back(one);
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[i]) mapped_q.push_back(found[i]);
   endfunction

   function automatic req_type random_fields();
      req_type r;
      r.opcode          = 1'($urandom_range(0, 1));
      r.source_kind     = 2'($urandom_range(0, 3));
      r.source_index    = 6'($urandom_range(0, 63));
      r.event_value     = 16'($urandom_range(0, 65535));
      r.slot            = 2'($urandom_range(0, 3));
      r.bind_valid      = 1'($urandom_range(0, 1));
      r.bind_dest_kind  = 1'($urandom_range(0, 1));
      r.bind_dest_code  = CODE_W'($urandom_range(0, 1023));
      r.bind_dest_range = 2'($urandom_range(0, 3));
      r.bind_src_range  = 2'($urandom_range(0, 3));
      r.bind_invert     = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic push_write(input logic [1:0] kind, input int idx, input int slot,
                             input logic dkind, input int code, input logic [1:0] drange,
                             input logic [1:0] srange, input logic inv);
      req_type r;
      r = random_fields();
      r.opcode          = OP_WRITE;
      r.source_kind     = kind;
      r.source_index    = 6'(idx);
      r.slot            = 2'(slot);
      r.bind_valid      = 1'b1;
      r.bind_dest_kind  = dkind;
      r.bind_dest_code  = CODE_W'(code);
      r.bind_dest_range = drange;
      r.bind_src_range  = srange;
      r.bind_invert     = inv;
      pending_q.push_back(r);
   endtask

   task automatic push_event(input logic [1:0] kind, input int idx, input int value);
      req_type r;
      r = random_fields();
      r.opcode       = OP_EVENT;
      r.source_kind  = kind;
      r.source_index = 6'(idx);
      r.event_value  = value[15:0];
      pending_q.push_back(r);
   endtask

   // Most traffic targets a few hot sources so events find live bindings.
   function automatic req_type random_item();
      req_type r;
      int      pick;
      r = random_fields();
      if ($urandom_range(0, 4) != 0) r.source_index = 6'(hot_index[$urandom_range(0, 3)]);
      pick = $urandom_range(0, 99);
      r.opcode = (pick < 30) ? OP_WRITE : OP_EVENT;
      r.source_kind = (pick >= 95) ? KIND_SPARE : 2'($urandom_range(0, 2));
      if (r.opcode == OP_WRITE) begin
         r.bind_valid = ($urandom_range(0, 7) != 0);
      end else if (r.source_kind == KIND_BUTTON) begin
         if ($urandom_range(0, 3) != 0) r.event_value = 16'($urandom_range(0, 1));
      end else if (r.source_kind == KIND_AXIS) begin
         case ($urandom_range(0, 6))
            0: r.event_value = 16'sd0;
            1: r.event_value = 16'sd16384 + $signed(4'($urandom_range(0, 2)) - 4'sd1);
            2: r.event_value = -16'sd16384 + $signed(4'($urandom_range(0, 2)) - 4'sd1);
            3: r.event_value = Q_ONE;
            4: r.event_value = Q_MIN;
            5: r.event_value = -Q_ONE;
            default: ;
         endcase
      end else if (r.source_kind == KIND_HAT) begin
         if ($urandom_range(0, 4) != 0) r.event_value = $signed(16'($urandom_range(0, 2))) - 16'sd1;
      end
      return r;
   endfunction

   task automatic wait_drained();
      while (!(pending_q.size() == 0 && sent_count == accept_count && mapped_q.size() == 0))
         @(posedge clock);
   endtask

   // Sender: bursts of items separated by idle gaps, some bursts gapless.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (sent_count != accept_count) begin
         // The current item is still waiting for ready.
      end else if (gap_left > 0) begin
         req_chan.valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0) begin
         req_chan.data  <= pending_q.pop_front();
         req_chan.valid <= 1'b1;
         sent_count     <= sent_count + 1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Receiver: cycles through always-ready, periodic, random and long-stall modes.
   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         case (stall_cycle[7:6])
            2'd0: rsp_chan.ready <= 1'b1;
            2'd1: rsp_chan.ready <= (stall_cycle % 3 == 0);
            2'd2: rsp_chan.ready <= 1'($urandom_range(0, 1));
            default: begin
               if (stall_left > 0) begin
                  rsp_chan.ready <= 1'b0;
                  stall_left <= stall_left - 1;
               end else begin
                  rsp_chan.ready <= 1'b1;
                  if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(2, 10);
               end
            end
         endcase
      end
   end

   // Results are checked before the item accepted on the same edge is predicted.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (mapped_q.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("[%0t] unexpected result: kind %0d code %0d axis %0d pressed %0d last %0d",
                        $realtime, rsp_chan.data.out_kind, rsp_chan.data.out_code,
                        rsp_chan.data.axis_value, rsp_chan.data.pressed, rsp_chan.data.last);
            mismatch_count++;
         end else begin
            want_rsp = mapped_q.pop_front();
            if (rsp_chan.data.out_kind !== want_rsp.out_kind ||
                rsp_chan.data.out_code !== want_rsp.out_code ||
                rsp_chan.data.axis_value !== want_rsp.axis_value ||
                rsp_chan.data.pressed !== want_rsp.pressed ||
                rsp_chan.data.last !== want_rsp.last) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("[%0t] result mismatch", $realtime);
                  $display("   expected: kind %0d code %0d axis %0d pressed %0d last %0d",
                           want_rsp.out_kind, want_rsp.out_code, want_rsp.axis_value,
                           want_rsp.pressed, want_rsp.last);
                  $display("   actual:   kind %0d code %0d axis %0d pressed %0d last %0d",
                           rsp_chan.data.out_kind, rsp_chan.data.out_code,
                           rsp_chan.data.axis_value, rsp_chan.data.pressed,
                           rsp_chan.data.last);
               end
               mismatch_count++;
            end
         end
      end
      if (!reset && req_chan.valid && req_chan.ready) begin
         remap_item(req_chan.data);
         accept_count <= accept_count + 1;
      end
   end

   initial begin
      #2_000_000;
      $display("gamepad_event_remapper verification failed");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      foreach (binding_mirror[k, i, s]) binding_mirror[k][i][s] = '0;

      // An event on a source with no bindings produces nothing.
      push_event(KIND_BUTTON, 0, 1);

      // Button source into the negative, full and spare axis ranges and a button destination.
      push_write(KIND_BUTTON, 63, 0, DEST_AXIS, 1023, RANGE_NEG, RANGE_FULL, 1'b0);
      push_write(KIND_BUTTON, 63, 1, DEST_AXIS, 0, RANGE_FULL, RANGE_FULL, 1'b0);
      push_write(KIND_BUTTON, 63, 2, DEST_BUTTON, 512, RANGE_POS, RANGE_FULL, 1'b1);
      push_write(KIND_BUTTON, 63, 3, DEST_AXIS, 7, RANGE_SPARE, RANGE_FULL, 1'b0);
      push_event(KIND_BUTTON, 63, 1);
      push_event(KIND_BUTTON, 63, 0);
      push_event(KIND_BUTTON, 63, -32768);

      // Axis source: inversion at both extremes, half-range rescaling, clipping
      // and the half-scale press threshold with an unused source range.
      push_write(KIND_AXIS, 5, 0, DEST_AXIS, 100, RANGE_FULL, RANGE_FULL, 1'b1);
      push_write(KIND_AXIS, 5, 1, DEST_AXIS, 101, RANGE_NEG, RANGE_NEG, 1'b0);
      push_write(KIND_AXIS, 5, 2, DEST_AXIS, 102, RANGE_POS, RANGE_POS, 1'b1);
      push_write(KIND_AXIS, 5, 3, DEST_BUTTON, 103, RANGE_FULL, RANGE_SPARE, 1'b1);
      push_event(KIND_AXIS, 5, -32768);
      push_event(KIND_AXIS, 5, 32767);
      push_event(KIND_AXIS, 5, 16385);
      push_event(KIND_AXIS, 5, 0);

      // Hat source: axis bindings on the opposite half stay silent, buttons release.
      push_write(KIND_HAT, 2, 0, DEST_AXIS, 200, RANGE_FULL, RANGE_NEG, 1'b0);
      push_write(KIND_HAT, 2, 1, DEST_AXIS, 201, RANGE_POS, RANGE_POS, 1'b0);
      push_write(KIND_HAT, 2, 2, DEST_BUTTON, 202, RANGE_FULL, RANGE_NEG, 1'b0);
      push_write(KIND_HAT, 2, 3, DEST_BUTTON, 203, RANGE_FULL, RANGE_FULL, 1'b0);
      push_event(KIND_HAT, 2, -1);
      push_event(KIND_HAT, 2, 1);
      push_event(KIND_HAT, 2, 0);
      push_event(KIND_HAT, 2, 3);

      // The unused source kind is ignored for writes and events alike.
      push_write(KIND_SPARE, 2, 0, DEST_AXIS, 300, RANGE_FULL, RANGE_FULL, 1'b0);
      push_event(KIND_SPARE, 2, 1);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait_drained();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pending_q.push_back(random_item());
         // Hold the sender once mid-run until every result has come back.
         if (n == RANDOM_ITEMS / 2) wait_drained();
      end
      wait_drained();
      repeat (40) @(posedge clock);

      $display("Covered %0d binding writes, %0d events and %0d ignored items;",
               writes_seen, events_seen, ignored_seen);
      $display("checked %0d mapped results, %0d of them wrong or unexpected.",
               results_seen, mismatch_count);
      if (mismatch_count == 0 && mapped_q.size() == 0) begin
         $display("gamepad_event_remapper verification clean");
      end else begin
         if (mapped_q.size() != 0) $display("%0d expected results never arrived", mapped_q.size());
         $display("gamepad_event_remapper verification failed");
      end
      $finish;
   end

endmodule
